/* design/lrl_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and defaults for the LRU recency list.
package lrl_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int KEY_WIDTH_DEF = 64;

    localparam int REQ_W    = 2;
    localparam int KEY_W    = 64;
    localparam int STATUS_W = 3;
    localparam int OCC_W    = 7;

    localparam logic [REQ_W-1:0] REQ_ACCESS = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [KEY_W-1:0] key;
    } req_beat_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [KEY_W-1:0]    key_out;
        logic [OCC_W-1:0]    occupancy;
    } rsp_beat_t;

    typedef struct packed {
        logic                load_req;
        logic                compare;
        logic                select;
        logic                unlink;
        logic                free_slot;
        logic                link;
        logic                insert;
        logic                pop_key;
        logic                load_rsp;
        logic [STATUS_W-1:0] status;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             hit;
        logic             full;
        logic             tail_hit;
        logic             empty;
        logic             rsp_free;
    } dp_sts_t;

endpackage

/* design/lrl_ctrl.sv */
`timescale 1ns / 1ps
// Sequencer for the LRU recency list: compare, select, unlink, link, respond.
module lrl_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  lrl_pkg::dp_sts_t  sts,
    output lrl_pkg::dp_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_COMPARE = 3'd1;
    localparam logic [2:0] S_SELECT  = 3'd2;
    localparam logic [2:0] S_DECIDE  = 3'd3;
    localparam logic [2:0] S_LINK    = 3'd4;
    localparam logic [2:0] S_DONE    = 3'd5;

    logic [2:0]                   state_reg;
    logic [2:0]                   state_next;
    logic [lrl_pkg::STATUS_W-1:0] status_reg;
    logic [lrl_pkg::STATUS_W-1:0] status_next;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_COMPARE;
                end
            end
            S_COMPARE:
            begin
                cmd.compare = 1'b1;
                state_next  = S_SELECT;
            end
            S_SELECT:
            begin
                cmd.select = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                state_next  = S_DONE;
                status_next = lrl_pkg::ST_NOTFOUND;
                case (sts.req_type)
                    lrl_pkg::REQ_ACCESS:
                    begin
                        if (sts.hit)
                        begin
                            status_next = lrl_pkg::ST_HIT;
                            // hit on the tail leaves the order as it is
                            if (!sts.tail_hit)
                            begin
                                cmd.unlink = 1'b1;
                                state_next = S_LINK;
                            end
                        end
                        else if (sts.full)
                        begin
                            status_next = lrl_pkg::ST_FULL;
                        end
                        else
                        begin
                            status_next = lrl_pkg::ST_INSERTED;
                            state_next  = S_LINK;
                        end
                    end
                    lrl_pkg::REQ_REMOVE:
                    begin
                        if (sts.hit)
                        begin
                            cmd.unlink    = 1'b1;
                            cmd.free_slot = 1'b1;
                            status_next   = lrl_pkg::ST_REMOVED;
                        end
                    end
                    lrl_pkg::REQ_POP:
                    begin
                        if (!sts.empty)
                        begin
                            cmd.unlink    = 1'b1;
                            cmd.free_slot = 1'b1;
                            cmd.pop_key   = 1'b1;
                            status_next   = lrl_pkg::ST_REMOVED;
                        end
                    end
                    default:
                    begin
                        status_next = lrl_pkg::ST_NOTFOUND;
                    end
                endcase
            end
            S_LINK:
            begin
                cmd.link   = 1'b1;
                cmd.insert = (status_reg == lrl_pkg::ST_INSERTED);
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (sts.rsp_free)
                begin
                    cmd.load_rsp = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign req_stall = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= lrl_pkg::ST_NOTFOUND;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

endmodule

/* design/lrl_datapath.sv */
`timescale 1ns / 1ps
// Key CAM, valid bits, link memories, head/tail/count and the response register.
module lrl_datapath
#(
    parameter int ENTRIES   = lrl_pkg::ENTRIES_DEF,
    parameter int KEY_WIDTH = lrl_pkg::KEY_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  lrl_pkg::req_beat_t req_beat,
    input  lrl_pkg::dp_cmd_t   cmd,
    output lrl_pkg::dp_sts_t   sts,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output lrl_pkg::rsp_beat_t rsp_beat
);

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int KEY_W = lrl_pkg::KEY_W;
    localparam int OCC_W = lrl_pkg::OCC_W;

    logic [lrl_pkg::REQ_W-1:0] req_reg;
    logic [KEY_WIDTH-1:0]      key_reg;
    logic [KEY_WIDTH-1:0]      key_store_reg [ENTRIES];
    logic [KEY_WIDTH-1:0]      kout_reg;

    logic [ENTRIES-1:0] entry_valid_reg;
    logic [ENTRIES-1:0] entry_valid_next;
    logic [ENTRIES-1:0] match_reg;
    logic [ENTRIES-1:0] free_oh_reg;
    logic               full_reg;
    logic               hit_reg;

    logic [IDX_W-1:0] match_idx;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] slot_reg;
    logic [IDX_W-1:0] slot_next;
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_reg;
    logic [IDX_W-1:0] tail_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic [IDX_W-1:0] prev_mem [ENTRIES];
    logic [IDX_W-1:0] next_mem [ENTRIES];
    logic [IDX_W-1:0] prev_rd_reg;
    logic [IDX_W-1:0] next_rd_reg;
    logic             prev_we;
    logic [IDX_W-1:0] prev_waddr;
    logic [IDX_W-1:0] prev_wdata;
    logic             next_we;
    logic [IDX_W-1:0] next_waddr;
    logic [IDX_W-1:0] next_wdata;

    logic               rsp_valid_reg;
    logic               rsp_valid_next;
    lrl_pkg::rsp_beat_t rsp_beat_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req_beat.req_type;
            key_reg <= KEY_WIDTH'(req_beat.key);
        end
    end

    // associative match plus lowest free slot, registered
    always_ff @(posedge clk)
    begin
        if (cmd.compare)
        begin
            for (int i = 0; i < ENTRIES; i++)
            begin
                match_reg[i] <= entry_valid_reg[i] && (key_store_reg[i] == key_reg);
            end
            free_oh_reg <= ~entry_valid_reg & (entry_valid_reg + ENTRIES'(1));
            full_reg    <= &entry_valid_reg;
        end
    end

    // keys are distinct, so the match vector is one-hot or zero
    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            if (match_reg[i])
            begin
                match_idx = match_idx | IDX_W'(i);
            end
            if (free_oh_reg[i])
            begin
                free_idx = free_idx | IDX_W'(i);
            end
        end
        if (req_reg == lrl_pkg::REQ_POP)
        begin
            slot_next = head_reg;
        end
        else if (|match_reg)
        begin
            slot_next = match_idx;
        end
        else
        begin
            slot_next = free_idx;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.select)
        begin
            slot_reg <= slot_next;
            hit_reg  <= |match_reg;
        end
    end

    always_comb
    begin
        prev_we          = 1'b0;
        prev_waddr       = next_rd_reg;
        prev_wdata       = prev_rd_reg;
        next_we          = 1'b0;
        next_waddr       = prev_rd_reg;
        next_wdata       = next_rd_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        entry_valid_next = entry_valid_reg;
        if (cmd.unlink)
        begin
            if (slot_reg == head_reg)
            begin
                head_next = next_rd_reg;
            end
            else
            begin
                next_we = 1'b1;
            end
            if (slot_reg == tail_reg)
            begin
                tail_next = prev_rd_reg;
            end
            else
            begin
                prev_we = 1'b1;
            end
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.free_slot)
        begin
            entry_valid_next[slot_reg] = 1'b0;
        end
        if (cmd.link)
        begin
            if (count_reg == '0)
            begin
                head_next = slot_reg;
            end
            else
            begin
                next_we    = 1'b1;
                next_waddr = tail_reg;
                next_wdata = slot_reg;
                prev_we    = 1'b1;
                prev_waddr = slot_reg;
                prev_wdata = tail_reg;
            end
            tail_next  = slot_reg;
            count_next = count_reg + CNT_W'(1);
        end
        if (cmd.insert)
        begin
            entry_valid_next[slot_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (cmd.select)
        begin
            prev_rd_reg <= prev_mem[slot_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (cmd.select)
        begin
            next_rd_reg <= next_mem[slot_next];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            key_store_reg[slot_reg] <= key_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            kout_reg <= '0;
        end
        else if (cmd.pop_key)
        begin
            kout_reg <= key_store_reg[slot_reg];
        end
    end

    assign rsp_valid_next = cmd.load_rsp ? 1'b1 : (rsp_valid_reg && rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            head_reg        <= '0;
            tail_reg        <= '0;
            count_reg       <= '0;
            rsp_valid_reg   <= 1'b0;
        end
        else
        begin
            entry_valid_reg <= entry_valid_next;
            head_reg        <= head_next;
            tail_reg        <= tail_next;
            count_reg       <= count_next;
            rsp_valid_reg   <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_rsp)
        begin
            rsp_beat_reg.status    <= cmd.status;
            rsp_beat_reg.key_out   <= KEY_W'(kout_reg);
            rsp_beat_reg.occupancy <= OCC_W'(count_reg);
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_beat  = rsp_beat_reg;

    assign sts.req_type = req_reg;
    assign sts.hit      = hit_reg;
    assign sts.full     = full_reg;
    assign sts.tail_hit = (slot_reg == tail_reg);
    assign sts.empty    = (count_reg == '0);
    assign sts.rsp_free = !rsp_valid_reg || !rsp_stall;

endmodule

/* design/lru_recency_list.sv */
`timescale 1ns / 1ps
// Top level of the LRU recency list: sequencer plus datapath.
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+--------------------------------------
//  request | req_valid | req_stall | req_beat: req_type, key
//  result  | rsp_valid | rsp_stall | rsp_beat: status, key_out, occupancy
//
// One beat in, one beat out. A new request is not taken until the last one's result
// is loaded: key compare, slot select with link read, unlink, link, result load,
// with the link step only when a relink is needed (move to tail or insert). The
// link memories with one write port each and registered read set these steps.
// Reset clears the valid bits, head, tail and count at once; no clearing pass.
// A stalled result holds in its register; a new request can be taken meanwhile.
module lru_recency_list
#(
    parameter int ENTRIES   = lrl_pkg::ENTRIES_DEF,
    parameter int KEY_WIDTH = lrl_pkg::KEY_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  lrl_pkg::req_beat_t req_beat,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output lrl_pkg::rsp_beat_t rsp_beat
);

    lrl_pkg::dp_cmd_t cmd;
    lrl_pkg::dp_sts_t sts;

    lrl_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    lrl_datapath
    #(
        .ENTRIES   (ENTRIES),
        .KEY_WIDTH (KEY_WIDTH)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_beat  (req_beat),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_beat  (rsp_beat)
    );

endmodule
